// ===== rtl/core/cdo_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar
// date offset unit. No dependencies; every other RTL file imports this package.
`default_nettype none

package cdo_pkg;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ORD_W   = 25;  // day ordinal from 0000-01-01, through year 65535
  localparam int MI_W    = 20;  // month index year*12 + month-1

  typedef enum logic [2:0] {
    OP_ADD_DAYS   = 3'd0,
    OP_ADD_MONTHS = 3'd1,
    OP_ADD_YEARS  = 3'd2,
    OP_SUB_DAYS   = 3'd3,
    OP_SUB_MONTHS = 3'd4,
    OP_SUB_YEARS  = 3'd5
  } op_t;

  typedef struct packed {
    logic [ORD_W-1:0] n;
    logic             limited;
  } ord_res_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               limited;
  } date_t;

  typedef struct packed {
    date_t date;
    logic  day_op;
  } my_res_t;

  // Pipeline depths of the two datapaths after the front stages
  localparam int D2O_LAT = 3;
  localparam int O2D_LAT = 6;
  localparam int MID_LAT = D2O_LAT + O2D_LAT;
  localparam int MY_LAT  = 5;
  localparam int MY_PAD  = MID_LAT - MY_LAT;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 16'hFFFF;
  localparam logic [MONTH_W-1:0] GAP_MONTH  = 4'd9;
  localparam logic [DAY_W-1:0]   GAP_FIRST  = 5'd3;
  localparam logic [DAY_W-1:0]   GAP_LAST   = 5'd13;
  localparam logic [DAY_W-1:0]   GAP_RESUME = 5'd14;
  localparam logic [ORD_W-1:0]   GAP_DAYS   = 25'd11;
  localparam logic [MI_W-1:0]    MONTH_TOP  = 20'd786431;  // December of year 65535

  // Reciprocal multipliers for division by constants
  localparam int               DIV100_SH  = 24;
  localparam logic [17:0]      DIV100_MUL = 18'((64'd1 << DIV100_SH) / 64'd100 + 64'd1);
  localparam int               DIV400_SH  = 26;
  localparam logic [17:0]      DIV400_MUL = 18'((64'd1 << DIV400_SH) / 64'd400 + 64'd1);
  localparam int               DIV3_SH    = 20;
  localparam logic [18:0]      DIV3_MUL   = 19'((64'd1 << DIV3_SH) / 64'd3 + 64'd1);
  localparam int               EST_SH     = 32;
  localparam logic [23:0]      EST_MUL    = 24'((64'd400 << EST_SH) / 64'd146097 + 64'd1);

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [8:0] CUM_DAYS [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304,
    9'd334
  };

  function automatic logic [9:0] div100(input logic [16:0] x);
    logic [34:0] p;
    p = 35'(x) * 35'(DIV100_MUL);
    return p[DIV100_SH +: 10];
  endfunction

  function automatic logic [7:0] div400(input logic [16:0] x);
    logic [34:0] p;
    p = 35'(x) * 35'(DIV400_MUL);
    return p[DIV400_SH +: 8];
  endfunction

  // Days from 0000-01-01 to the start of year c, given ceil terms as quotients
  function automatic logic [ORD_W-1:0] ys_sum(input logic [16:0] c, input logic [9:0] q100,
                                               input logic [7:0] q400);
    logic [16:0] c3;
    c3 = c + 17'd3;
    return ORD_W'(c) * ORD_W'(365) + ORD_W'(c3[16:2]) + ORD_W'(q400) - ORD_W'(q100);
  endfunction

  // q is floor(y / 100)
  function automatic logic leap_of(input logic [YEAR_W-1:0] y, input logic [9:0] q);
    return (y[1:0] == 2'd0) && ((YEAR_W'(q) * YEAR_W'(100) != y) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - 4'd1;
    if (m == 4'd2 && leap) return 5'd29;
    return MONTH_LEN[idx];
  endfunction

  // Days of the year before the first of month m
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m, input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - 4'd1;
    return CUM_DAYS[idx] + 9'(leap && (m > 4'd2));
  endfunction

  function automatic logic [DAY_W-1:0] fix_day(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m,
                                               input logic [DAY_W-1:0] d, input logic leap,
                                               input logic [YEAR_W-1:0] cy);
    logic [DAY_W-1:0] len;
    logic [DAY_W-1:0] r;
    len = days_in(m, leap);
    r = (d == 5'd0) ? 5'd1 : d;
    if (r > len) r = len;
    if (y == cy && m == GAP_MONTH && r >= GAP_FIRST && r <= GAP_LAST) r = GAP_RESUME;
    return r;
  endfunction

  // Elaboration-time helpers
  function automatic logic leap_const(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [ORD_W-1:0] ys_const(input longint y);
    return ORD_W'(365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400);
  endfunction

  localparam logic [ORD_W-1:0] ORD_TOP = ys_const(65536) - 25'd12;

endpackage

`default_nettype wire

// ===== rtl/core/cdo_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
// Depends on cdo_pkg for field widths.
`default_nettype none

interface cdo_cmd_if
  import cdo_pkg::*;
#(parameter int AMOUNT_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [2:0]             operation;
  logic [YEAR_W-1:0]      start_year;
  logic [MONTH_W-1:0]     start_month;
  logic [DAY_W-1:0]       start_day;
  logic [AMOUNT_BITS-1:0] amount;

  modport source (output valid, operation, start_year, start_month, start_day, amount,
                  input ready);
  modport sink (input valid, operation, start_year, start_month, start_day, amount,
                output ready);
endinterface

interface cdo_res_if
  import cdo_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  result_year;
  logic [MONTH_W-1:0] result_month;
  logic [DAY_W-1:0]   result_day;
  logic               year_limited;

  modport source (output valid, result_year, result_month, result_day, year_limited,
                  input ready);
  modport sink (input valid, result_year, result_month, result_day, year_limited,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/calendar_date_offset_unit_core.sv =====
// Top level of the calendar date offset unit: front normalization stages,
// day path (cdo_date_to_ord, cdo_ord_to_date), month/year path, output register.
// Depends on cdo_pkg, cdo_if, cdo_date_to_ord, cdo_ord_to_date, cdo_month_year.
//
//  channel | dir | transaction payload
//  --------+-----+-------------------------------------------------------------
//  cmd     | in  | operation, start_year, start_month, start_day, amount
//  res     | out | result_year, result_month, result_day, year_limited
//
//  Flow: one transaction accepted per clock while res is not stalled. The
//  depth is set by the day path: ordinal build (3 stages), year estimate
//  and candidate check plus month search (6).
//  Reset: rst clears all valid bits; payload registers are not reset.
//  Stalls: the whole pipeline holds while res is valid and not taken, and
//  cmd.ready drops with it, so no transaction is lost or repeated.
`default_nettype none

module calendar_date_offset_unit_core
  import cdo_pkg::*;
#(
  parameter int AMOUNT_BITS  = 16,
  parameter int CUTOVER_YEAR = 1752
) (
  input  logic      clk,
  input  logic      rst,
  cdo_cmd_if.sink   cmd,
  cdo_res_if.source res
);

  localparam logic [YEAR_W-1:0] CY = YEAR_W'(CUTOVER_YEAR);

  // Global advance: move every stage when the output slot is free or drained
  logic en;
  assign en = !res.valid || res.ready;
  assign cmd.ready = en;

  // Stage s1: capture, clamp the month, start the century quotient
  logic                   s1_vld;
  logic [2:0]             s1_op;
  logic [YEAR_W-1:0]      s1_y;
  logic [MONTH_W-1:0]     s1_m;
  logic [DAY_W-1:0]       s1_d;
  logic [AMOUNT_BITS-1:0] s1_amt;
  logic [9:0]             s1_q;

  // Stage s2: normalized start date
  logic                   s2_vld;
  logic [2:0]             s2_op;
  logic [YEAR_W-1:0]      s2_y;
  logic [MONTH_W-1:0]     s2_m;
  logic [DAY_W-1:0]       s2_d;
  logic                   s2_leap;
  logic [AMOUNT_BITS-1:0] s2_amt;

  logic [MID_LAT-1:0]     mid_vld;
  logic [MONTH_W-1:0]     m_clamp;
  logic                   leap_start;

  ord_res_t               ord;
  date_t                  day_date;
  my_res_t                my_res;
  date_t                  pick;

  always_comb begin
    priority if (cmd.start_month == 4'd0) m_clamp = 4'd1;
    else if (cmd.start_month > 4'd12) m_clamp = 4'd12;
    else m_clamp = cmd.start_month;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op  <= cmd.operation;
      s1_y   <= cmd.start_year;
      s1_m   <= m_clamp;
      s1_d   <= cmd.start_day;
      s1_amt <= cmd.amount;
      s1_q   <= div100(17'(cmd.start_year));
    end
  end

  // Clamp the start day to its month and move a date inside the gap forward
  assign leap_start = leap_of(s1_y, s1_q);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op   <= s1_op;
      s2_y    <= s1_y;
      s2_m    <= s1_m;
      s2_d    <= fix_day(s1_y, s1_m, s1_d, leap_start, CY);
      s2_leap <= leap_start;
      s2_amt  <= s1_amt;
    end
  end

  // Day path
  cdo_date_to_ord #(
    .AMOUNT_BITS  (AMOUNT_BITS),
    .CUTOVER_YEAR (CUTOVER_YEAR)
  ) u_d2o (
    .clk    (clk),
    .en     (en),
    .op     (s2_op),
    .year   (s2_y),
    .month  (s2_m),
    .day    (s2_d),
    .leap   (s2_leap),
    .amount (s2_amt),
    .res    (ord)
  );

  cdo_ord_to_date #(
    .CUTOVER_YEAR (CUTOVER_YEAR)
  ) u_o2d (
    .clk (clk),
    .en  (en),
    .src (ord),
    .dst (day_date)
  );

  // Month, year and pass-through path, same depth as the day path
  cdo_month_year #(
    .AMOUNT_BITS  (AMOUNT_BITS),
    .CUTOVER_YEAR (CUTOVER_YEAR)
  ) u_my (
    .clk    (clk),
    .en     (en),
    .op     (s2_op),
    .year   (s2_y),
    .month  (s2_m),
    .day    (s2_d),
    .amount (s2_amt),
    .dst    (my_res)
  );

  // Valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      mid_vld   <= '0;
      res.valid <= 1'b0;
    end else if (en) begin
      s1_vld    <= cmd.valid;
      s2_vld    <= s1_vld;
      mid_vld   <= {mid_vld[MID_LAT-2:0], s2_vld};
      res.valid <= mid_vld[MID_LAT-1];
    end
  end

  // Select the path by operation class and load the output register
  assign pick = my_res.day_op ? day_date : my_res.date;

  always_ff @(posedge clk) begin
    if (en) begin
      res.result_year  <= pick.year;
      res.result_month <= pick.month;
      res.result_day   <= pick.day;
      res.year_limited <= pick.limited;
    end
  end

  // A limited result always sits at an end of the year range
  a_limit_edge: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.year_limited |-> (res.result_year == 16'd0) ||
                                      (res.result_year == YEAR_MAX))
    else $error("limited result away from the year range ends");

  // No result falls inside the dropped days of the cutover year
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.result_year == CY) && (res.result_month == GAP_MONTH) |->
      (res.result_day < GAP_FIRST) || (res.result_day > GAP_LAST))
    else $error("result inside the cutover gap");

  // Results are well-formed dates
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.result_month >= 4'd1) && (res.result_month <= 4'd12) &&
                  (res.result_day >= 5'd1))
    else $error("malformed result date");

  // An accepted command occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> s1_vld)
    else $error("accepted command lost at pipeline entry");

endmodule

`default_nettype wire

// ===== rtl/core/cdo_date_to_ord.sv =====
// Date to day ordinal conversion with day offset and saturation, three stages.
// Depends on cdo_pkg.
`default_nettype none

module cdo_date_to_ord
  import cdo_pkg::*;
#(
  parameter int AMOUNT_BITS  = 16,
  parameter int CUTOVER_YEAR = 1752
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2:0]             op,
  input  logic [YEAR_W-1:0]      year,
  input  logic [MONTH_W-1:0]     month,
  input  logic [DAY_W-1:0]       day,
  input  logic                   leap,
  input  logic [AMOUNT_BITS-1:0] amount,
  output ord_res_t               res
);

  localparam logic [YEAR_W-1:0] CY = YEAR_W'(CUTOVER_YEAR);
  localparam int SW = ((AMOUNT_BITS > ORD_W) ? AMOUNT_BITS : ORD_W) + 1;

  logic [2:0]             a_op;
  logic [AMOUNT_BITS-1:0] a_amt;
  logic [YEAR_W-1:0]      a_y;
  logic [9:0]             a_q100;
  logic [7:0]             a_q400;
  logic [9:0]             a_off;

  logic [2:0]             b_op;
  logic [AMOUNT_BITS-1:0] b_amt;
  logic [ORD_W-1:0]       b_ord;

  logic                   after_gap;
  logic [9:0]             off_next;
  logic [SW-1:0]          sum;
  ord_res_t               res_next;

  // Stage 1: century quotients and offset within the year
  always_comb begin
    after_gap = (year > CY) ||
                ((year == CY) && ((month > GAP_MONTH) ||
                                  ((month == GAP_MONTH) && (day > GAP_LAST))));
    off_next = 10'(cum_days(month, leap)) + 10'(day) - 10'd1 -
               (after_gap ? 10'(GAP_DAYS) : 10'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op   <= op;
      a_amt  <= amount;
      a_y    <= year;
      a_q100 <= div100(17'(year) + 17'd99);
      a_q400 <= div400(17'(year) + 17'd399);
      a_off  <= off_next;
    end
  end

  // Stage 2: ordinal of the start date
  always_ff @(posedge clk) begin
    if (en) begin
      b_op  <= a_op;
      b_amt <= a_amt;
      b_ord <= ys_sum(17'(a_y), a_q100, a_q400) + {{(ORD_W-10){a_off[9]}}, a_off};
    end
  end

  // Stage 3: apply the day offset, hold at the ends of the range
  always_comb begin
    sum = SW'(b_ord) + SW'(b_amt);
    res_next.n = b_ord;
    res_next.limited = 1'b0;
    if (b_op == OP_ADD_DAYS) begin
      if (sum > SW'(ORD_TOP)) begin
        res_next.n = ORD_TOP;
        res_next.limited = 1'b1;
      end else begin
        res_next.n = sum[ORD_W-1:0];
      end
    end else if (b_op == OP_SUB_DAYS) begin
      if (SW'(b_amt) > SW'(b_ord)) begin
        res_next.n = '0;
        res_next.limited = 1'b1;
      end else begin
        res_next.n = ORD_W'(SW'(b_ord) - SW'(b_amt));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cdo_ord_to_date.sv =====
// Day ordinal back to calendar date: year estimate, candidate check, month search.
// Six stages. Depends on cdo_pkg.
`default_nettype none

module cdo_ord_to_date
  import cdo_pkg::*;
#(
  parameter int CUTOVER_YEAR = 1752
) (
  input  logic     clk,
  input  logic     en,
  input  ord_res_t src,
  output date_t    dst
);

  localparam logic [ORD_W-1:0] GAP_START = ys_const(longint'(CUTOVER_YEAR)) +
      ORD_W'(cum_days(GAP_MONTH, leap_const(longint'(CUTOVER_YEAR)))) + ORD_W'(2);

  logic [ORD_W-1:0] a_n;
  logic             a_flag;
  logic [ORD_W-1:0] b_n;
  logic             b_flag;
  logic [16:0]      b_est;
  logic [ORD_W-1:0] c_n;
  logic             c_flag;
  logic [16:0]      c_est;
  logic [16:0]      c_y    [4];
  logic [9:0]       c_q100 [4];
  logic [7:0]       c_q400 [4];
  logic [ORD_W-1:0] d_n;
  logic             d_flag;
  logic [16:0]      d_est;
  logic [ORD_W-1:0] d_ys   [4];
  logic [YEAR_W-1:0] e_y;
  logic [8:0]       e_r;
  logic             e_leap;
  logic             e_flag;

  logic [23+ORD_W:0] est_prod;
  logic [16:0]       cand [4];
  logic [1:0]        sel;
  logic [ORD_W-1:0]  pick_ys;
  logic [ORD_W-1:0]  pick_len;
  logic [16:0]       pick_y;
  logic [MONTH_W-1:0] mm;
  date_t             dst_next;

  // Stage 1: skip the cutover gap
  always_ff @(posedge clk) begin
    if (en) begin
      a_n    <= src.n + ((src.n >= GAP_START) ? GAP_DAYS : '0);
      a_flag <= src.limited;
    end
  end

  // Stage 2: year estimate, within one of the true year
  assign est_prod = (24+ORD_W)'(a_n) * (24+ORD_W)'(EST_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      b_n    <= a_n;
      b_flag <= a_flag;
      b_est  <= est_prod[EST_SH +: 17];
    end
  end

  // Stage 3: century quotients for years est-1 .. est+2
  always_comb begin
    cand[0] = (b_est == 17'd0) ? 17'd0 : b_est - 17'd1;
    for (int i = 1; i < 4; i++) cand[i] = b_est + 17'(i - 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_n    <= b_n;
      c_flag <= b_flag;
      c_est  <= b_est;
      for (int i = 0; i < 4; i++) begin
        c_y[i]    <= cand[i];
        c_q100[i] <= div100(cand[i] + 17'd99);
        c_q400[i] <= div400(cand[i] + 17'd399);
      end
    end
  end

  // Stage 4: year starts of the candidates
  always_ff @(posedge clk) begin
    if (en) begin
      d_n    <= c_n;
      d_flag <= c_flag;
      d_est  <= c_est;
      for (int i = 0; i < 4; i++) d_ys[i] <= ys_sum(c_y[i], c_q100[i], c_q400[i]);
    end
  end

  // Stage 5: pick the year that holds the ordinal
  always_comb begin
    priority if (d_n < d_ys[1]) sel = 2'd0;
    else if (d_n >= d_ys[2]) sel = 2'd2;
    else sel = 2'd1;
    unique case (sel)
      2'd0: begin
        pick_ys  = d_ys[0];
        pick_len = d_ys[1] - d_ys[0];
        pick_y   = d_est - 17'd1;
      end
      2'd2: begin
        pick_ys  = d_ys[2];
        pick_len = d_ys[3] - d_ys[2];
        pick_y   = d_est + 17'd1;
      end
      default: begin
        pick_ys  = d_ys[1];
        pick_len = d_ys[2] - d_ys[1];
        pick_y   = d_est;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_y    <= pick_y[YEAR_W-1:0];
      e_r    <= 9'(d_n - pick_ys);
      e_leap <= (pick_len == ORD_W'(366));
      e_flag <= d_flag;
    end
  end

  // Stage 6: month search over the cumulative table
  always_comb begin
    mm = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (e_r >= cum_days(MONTH_W'(k), e_leap)) mm = mm + 4'd1;
    end
    dst_next.year    = e_y;
    dst_next.month   = mm;
    dst_next.day     = 5'(e_r - cum_days(mm, e_leap) + 9'd1);
    dst_next.limited = e_flag;
  end

  always_ff @(posedge clk) begin
    if (en) dst <= dst_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cdo_month_year.sv =====
// Month and year steps with saturation and day clamping; also passes the start
// date for unused operation codes. Padded to the day path depth. Depends on cdo_pkg.
`default_nettype none

module cdo_month_year
  import cdo_pkg::*;
#(
  parameter int AMOUNT_BITS  = 16,
  parameter int CUTOVER_YEAR = 1752
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2:0]             op,
  input  logic [YEAR_W-1:0]      year,
  input  logic [MONTH_W-1:0]     month,
  input  logic [DAY_W-1:0]       day,
  input  logic [AMOUNT_BITS-1:0] amount,
  output my_res_t                dst
);

  localparam logic [YEAR_W-1:0] CY = YEAR_W'(CUTOVER_YEAR);
  localparam int TW = ((AMOUNT_BITS > MI_W) ? AMOUNT_BITS : MI_W) + 1;
  localparam int YW = ((AMOUNT_BITS > YEAR_W) ? AMOUNT_BITS : YEAR_W) + 1;

  typedef struct packed {
    logic               day_op;
    logic               is_month;
    logic               limited;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
  } side_t;

  side_t              s1, s2, s3, s4;
  logic [MI_W-1:0]    t1, t2;
  logic [YEAR_W-1:0]  y1, y2, y3, y4;
  logic [YEAR_W-1:0]  q3;
  logic [9:0]         q4;
  my_res_t            line [MY_PAD+1];

  logic [MI_W-1:0]    ym;
  logic [TW-1:0]      tsum;
  logic [YW-1:0]      ysum;
  side_t              s1_next;
  logic [MI_W-1:0]    t1_next;
  logic [YEAR_W-1:0]  y1_next;
  logic [36:0]        div3_prod;
  logic [MI_W-1:0]    rem12;
  side_t              s3_next;
  my_res_t            fin;

  // Stage 1: step the month index or the year
  always_comb begin
    ym   = MI_W'(year) * MI_W'(12) + MI_W'(month - 4'd1);
    tsum = TW'(ym) + TW'(amount);
    ysum = YW'(year) + YW'(amount);
    s1_next.day_op   = (op == OP_ADD_DAYS) || (op == OP_SUB_DAYS);
    s1_next.is_month = 1'b0;
    s1_next.limited  = 1'b0;
    s1_next.m        = month;
    s1_next.d        = day;
    t1_next          = ym;
    y1_next          = year;
    unique case (op)
      OP_ADD_MONTHS: begin
        s1_next.is_month = 1'b1;
        if (tsum > TW'(MONTH_TOP)) begin
          t1_next = MONTH_TOP;
          s1_next.limited = 1'b1;
        end else begin
          t1_next = tsum[MI_W-1:0];
        end
      end
      OP_SUB_MONTHS: begin
        s1_next.is_month = 1'b1;
        if (TW'(amount) > TW'(ym)) begin
          t1_next = '0;
          s1_next.limited = 1'b1;
        end else begin
          t1_next = MI_W'(TW'(ym) - TW'(amount));
        end
      end
      OP_ADD_YEARS: begin
        if (ysum > YW'(YEAR_MAX)) begin
          y1_next = YEAR_MAX;
          s1_next.limited = 1'b1;
        end else begin
          y1_next = ysum[YEAR_W-1:0];
        end
      end
      OP_SUB_YEARS: begin
        if (YW'(amount) > YW'(year)) begin
          y1_next = '0;
          s1_next.limited = 1'b1;
        end else begin
          y1_next = YEAR_W'(YW'(year) - YW'(amount));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      t1 <= t1_next;
      y1 <= y1_next;
    end
  end

  // Stage 2: year of the month index, t / 12 as (t / 4) / 3
  assign div3_prod = 37'(t1[MI_W-1:2]) * 37'(DIV3_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s1;
      t2 <= t1;
      y2 <= y1;
      q3 <= div3_prod[DIV3_SH +: YEAR_W];
    end
  end

  // Stage 3: split the month index
  assign rem12 = t2 - MI_W'(q3) * MI_W'(12);

  always_comb begin
    s3_next   = s2;
    s3_next.m = s2.is_month ? (MONTH_W'(rem12) + 4'd1) : s2.m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s3_next;
      y3 <= s2.is_month ? q3 : y2;
    end
  end

  // Stage 4: century quotient for the leap test
  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= s3;
      y4 <= y3;
      q4 <= div100(17'(y3));
    end
  end

  // Stage 5: clamp the day to the new month
  always_comb begin
    fin.day_op       = s4.day_op;
    fin.date.year    = y4;
    fin.date.month   = s4.m;
    fin.date.day     = fix_day(y4, s4.m, s4.d, leap_of(y4, q4), CY);
    fin.date.limited = s4.limited;
  end

  // Delay line to line up with the day path
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= fin;
      for (int i = 1; i <= MY_PAD; i++) line[i] <= line[i-1];
    end
  end

  assign dst = line[MY_PAD];

endmodule

`default_nettype wire
